>>> rtl/brs_pkg.sv
package brs_pkg;

  // parameter defaults
  localparam int COLUMN_BITS_DEF = 12;
  localparam int COUNT_BITS_DEF  = 20;

  // fixed field widths
  localparam int PIX_W      = 8;
  localparam int LEVEL_W    = 8;
  localparam int BAND_W     = 12;
  localparam int LIMIT_W    = 20;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam int CMD_W      = 2;

  // register indexes on the config port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BRIGHT_LEVEL = 3'd0,
    CFG_BAND_WIDTH   = 3'd1,
    CFG_RIGHT_START  = 3'd2,
    CFG_NEAR_LIMIT   = 3'd3,
    CFG_FAR_LIMIT    = 3'd4
  } cfg_idx_e;

  // register reset values
  localparam logic [LEVEL_W-1:0] RST_BRIGHT_LEVEL = 8'd240;
  localparam logic [BAND_W-1:0]  RST_BAND_WIDTH   = 12'd213;
  localparam logic [BAND_W-1:0]  RST_RIGHT_START  = 12'd426;
  localparam logic [LIMIT_W-1:0] RST_NEAR_LIMIT   = 20'd6500;
  localparam logic [LIMIT_W-1:0] RST_FAR_LIMIT    = 20'd7000;

  // q14 luma weights, round half up
  localparam int GRAY_SUM_W = 22;
  localparam int GRAY_SHIFT = 14;
  localparam int PROD_R_W   = 21;
  localparam int PROD_G_W   = 22;
  localparam int PROD_B_W   = 19;
  localparam logic [PROD_R_W-1:0]   W_RED      = 21'd4899;
  localparam logic [PROD_G_W-1:0]   W_GREEN    = 22'd9617;
  localparam logic [PROD_B_W-1:0]   W_BLUE     = 19'd1868;
  localparam logic [GRAY_SUM_W-1:0] GRAY_ROUND = 22'd8192;

  // drive command codes, two's complement
  localparam logic [CMD_W-1:0] CMD_POS  = 2'b01;
  localparam logic [CMD_W-1:0] CMD_ZERO = 2'b00;
  localparam logic [CMD_W-1:0] CMD_NEG  = 2'b11;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = 2;

  typedef struct packed {
    logic [LEVEL_W-1:0] bright_level;
    logic [BAND_W-1:0]  band_width;
    logic [BAND_W-1:0]  right_start;
    logic [LIMIT_W-1:0] near_limit;
    logic [LIMIT_W-1:0] far_limit;
  } cfg_t;

  typedef struct packed {
    logic hit_left;
    logic hit_center;
    logic hit_right;
    logic last;
  } class_t;

endpackage

>>> rtl/brs_front.sv
module brs_front #(
  parameter int COLUMN_BITS = brs_pkg::COLUMN_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  brs_pkg::cfg_t              cfg_i,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  logic [brs_pkg::PIX_W-1:0]  red_i,
  input  logic [brs_pkg::PIX_W-1:0]  green_i,
  input  logic [brs_pkg::PIX_W-1:0]  blue_i,
  input  logic [COLUMN_BITS-1:0]     column_i,
  input  logic                       last_i,
  output logic                       push_o,
  output brs_pkg::class_t            item_o,
  input  logic                       full_i
);
  import brs_pkg::*;

  localparam int CmpW = (COLUMN_BITS > BAND_W ? COLUMN_BITS : BAND_W) + 1;

  logic                   s1_valid_q;
  logic [PROD_R_W-1:0]    prod_r_q;
  logic [PROD_G_W-1:0]    prod_g_q;
  logic [PROD_B_W-1:0]    prod_b_q;
  logic [COLUMN_BITS-1:0] col_q;
  logic                   last_q;

  logic [GRAY_SUM_W-1:0]  gray_sum;
  logic [PIX_W-1:0]       gray;
  logic                   bright;
  logic [CmpW-1:0]        col_x;
  logic [CmpW-1:0]        w_x;
  logic [CmpW-1:0]        rs_x;

  // stage holds while the queue is full
  assign ready_o = !s1_valid_q || !full_i;
  assign push_o  = s1_valid_q && !full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (ready_o) begin
      s1_valid_q <= valid_i;
    end
  end

  // weight products
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      prod_r_q <= PROD_R_W'(red_i) * W_RED;
      prod_g_q <= PROD_G_W'(green_i) * W_GREEN;
      prod_b_q <= PROD_B_W'(blue_i) * W_BLUE;
      col_q    <= column_i;
      last_q   <= last_i;
    end
  end

  // gray level and bright test
  assign gray_sum = GRAY_SUM_W'(prod_r_q) + prod_g_q + GRAY_SUM_W'(prod_b_q) + GRAY_ROUND;
  assign gray     = gray_sum[GRAY_SUM_W-1:GRAY_SHIFT];
  assign bright   = gray > cfg_i.bright_level;

  // band membership, bounds without wrap
  assign col_x = CmpW'(col_q);
  assign w_x   = CmpW'(cfg_i.band_width);
  assign rs_x  = CmpW'(cfg_i.right_start);

  always_comb begin
    item_o.hit_left   = bright && (col_x < w_x);
    item_o.hit_center = bright && (col_x >= w_x) && (col_x < (w_x << 1));
    item_o.hit_right  = bright && (col_x >= rs_x) && (col_x < (rs_x + w_x));
    item_o.last       = last_q;
  end

endmodule

>>> rtl/brs_queue.sv
module brs_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  brs_pkg::class_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            avail_o,
  output brs_pkg::class_t item_o
);
  import brs_pkg::*;

  class_t                 mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q;
  logic [QUEUE_PTR_W-1:0] rd_ptr_q;
  logic [QUEUE_PTR_W:0]   count_q;

  assign full_o  = count_q == (QUEUE_PTR_W+1)'(QUEUE_DEPTH);
  assign avail_o = count_q != '0;
  assign item_o  = mem_q[rd_ptr_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= item_i;
  end

endmodule

>>> rtl/brs_back.sv
module brs_back #(
  parameter int COUNT_BITS = brs_pkg::COUNT_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  brs_pkg::cfg_t              cfg_i,
  input  logic                       avail_i,
  input  brs_pkg::class_t            item_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [COUNT_BITS-1:0]      left_count_o,
  output logic [COUNT_BITS-1:0]      center_count_o,
  output logic [COUNT_BITS-1:0]      right_count_o,
  output logic [brs_pkg::CMD_W-1:0]  linear_cmd_o,
  output logic [brs_pkg::CMD_W-1:0]  turn_cmd_o
);
  import brs_pkg::*;

  localparam int LimW = (COUNT_BITS > LIMIT_W ? COUNT_BITS : LIMIT_W);

  logic [COUNT_BITS-1:0] left_q, center_q, right_q;
  logic [COUNT_BITS-1:0] left_d, center_d, right_d;

  logic                  a_valid_q;
  logic [COUNT_BITS-1:0] a_left_q, a_center_q, a_right_q;
  logic                  b_valid_q;

  logic                  b_take;
  logic                  a_adv;
  logic                  a_free;
  logic                  take_last;

  logic [COUNT_BITS-1:0] max_lc;
  logic [COUNT_BITS-1:0] max_all;
  logic [LimW-1:0]       max_x;
  logic [CMD_W-1:0]      lin_d;
  logic [CMD_W-1:0]      turn_d;

  // handshake between accumulate, decide and output stages
  assign b_take    = !b_valid_q || out_ready_i;
  assign a_adv     = a_valid_q && b_take;
  assign a_free    = !a_valid_q || b_take;
  assign pop_o     = avail_i && (!item_i.last || a_free);
  assign take_last = pop_o && item_i.last;

  // saturating increments
  always_comb begin
    left_d   = left_q;
    center_d = center_q;
    right_d  = right_q;
    if (item_i.hit_left   && (left_q   != '1)) left_d   = left_q + 1'b1;
    if (item_i.hit_center && (center_q != '1)) center_d = center_q + 1'b1;
    if (item_i.hit_right  && (right_q  != '1)) right_d  = right_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q    <= '0;
      center_q  <= '0;
      right_q   <= '0;
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (take_last) begin
        left_q   <= '0;
        center_q <= '0;
        right_q  <= '0;
      end else if (pop_o) begin
        left_q   <= left_d;
        center_q <= center_d;
        right_q  <= right_d;
      end
      if (take_last)  a_valid_q <= 1'b1;
      else if (a_adv) a_valid_q <= 1'b0;
      if (a_adv)            b_valid_q <= 1'b1;
      else if (out_ready_i) b_valid_q <= 1'b0;
    end
  end

  // frame totals and result register
  always_ff @(posedge clk_i) begin
    if (take_last) begin
      a_left_q   <= left_d;
      a_center_q <= center_d;
      a_right_q  <= right_d;
    end
    if (a_adv) begin
      left_count_o   <= a_left_q;
      center_count_o <= a_center_q;
      right_count_o  <= a_right_q;
      linear_cmd_o   <= lin_d;
      turn_cmd_o     <= turn_d;
    end
  end

  // largest count and drive command
  assign max_lc  = (a_center_q > a_left_q) ? a_center_q : a_left_q;
  assign max_all = (a_right_q > max_lc) ? a_right_q : max_lc;
  assign max_x   = LimW'(max_all);

  always_comb begin
    if (max_x < LimW'(cfg_i.near_limit))     lin_d = CMD_POS;
    else if (max_x > LimW'(cfg_i.far_limit)) lin_d = CMD_NEG;
    else                                     lin_d = CMD_ZERO;
    turn_d = CMD_ZERO;
    if ((a_left_q > a_center_q) && (a_left_q > a_right_q)) begin
      turn_d = CMD_NEG;
    end else if ((a_center_q > a_left_q) && (a_center_q > a_right_q)) begin
      turn_d = CMD_ZERO;
    end else if ((a_right_q > a_left_q) && (a_right_q > a_center_q)) begin
      turn_d = CMD_POS;
    end else begin
      // tie for the largest count: stop
      lin_d  = CMD_ZERO;
      turn_d = CMD_ZERO;
    end
  end

  assign out_valid_o = b_valid_q;

endmodule

>>> rtl/bright_region_steering.sv
// channel   dir  beat contents (tdata from bit 0 up)
// s_axis    in   red[7:0], green[7:0], blue[7:0], column; tlast = frame_end
// m_axis    out  left_count, center_count, right_count, linear_cmd[1:0], turn_cmd[1:0]
// cfg       in   cfg_we_i / cfg_idx_i / cfg_data_i, one register per write
//
// one pixel beat per cycle sustained while the queue has room; one result beat per frame-end pixel
// a frame-end beat passes the pixel stage, the queue, the decide stage and the result register
// throughput is set by the single pixel stage and the one-pop-per-cycle accumulator
// (frame-end pops wait for a free decide stage); a four-entry queue separates them
// rst_ni clears band counts, pipeline valids, queue pointers, config to defaults
// m_axis_tready low holds the result; the queue then fills and s_axis_tready drops
module bright_region_steering #(
  parameter int COLUMN_BITS = brs_pkg::COLUMN_BITS_DEF,
  parameter int COUNT_BITS  = brs_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // red, green, blue, column
  input  logic [((3*brs_pkg::PIX_W+COLUMN_BITS+7)/8)*8-1:0] s_axis_tdata,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic                                s_axis_tlast,
  // left_count, center_count, right_count, linear_cmd, turn_cmd
  output logic [((3*COUNT_BITS+2*brs_pkg::CMD_W+7)/8)*8-1:0] m_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  input  logic                                cfg_we_i,
  input  logic [brs_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [brs_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import brs_pkg::*;

  localparam int OutUsed = 3*COUNT_BITS + 2*CMD_W;
  localparam int OutW    = ((OutUsed + 7) / 8) * 8;

  cfg_t   cfg_q;
  logic   push;
  class_t push_item;
  logic   full;
  logic   pop;
  logic   avail;
  class_t pop_item;

  logic [COUNT_BITS-1:0] left_count, center_count, right_count;
  logic [CMD_W-1:0]      linear_cmd, turn_cmd;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bright_level <= RST_BRIGHT_LEVEL;
      cfg_q.band_width   <= RST_BAND_WIDTH;
      cfg_q.right_start  <= RST_RIGHT_START;
      cfg_q.near_limit   <= RST_NEAR_LIMIT;
      cfg_q.far_limit    <= RST_FAR_LIMIT;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BRIGHT_LEVEL: cfg_q.bright_level <= cfg_data_i[LEVEL_W-1:0];
        CFG_BAND_WIDTH:   cfg_q.band_width   <= cfg_data_i[BAND_W-1:0];
        CFG_RIGHT_START:  cfg_q.right_start  <= cfg_data_i[BAND_W-1:0];
        CFG_NEAR_LIMIT:   cfg_q.near_limit   <= cfg_data_i[LIMIT_W-1:0];
        CFG_FAR_LIMIT:    cfg_q.far_limit    <= cfg_data_i[LIMIT_W-1:0];
        default:          cfg_q <= cfg_q;
      endcase
    end
  end

  // pixel classification
  brs_front #(
    .COLUMN_BITS(COLUMN_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .valid_i  (s_axis_tvalid),
    .ready_o  (s_axis_tready),
    .red_i    (s_axis_tdata[PIX_W-1:0]),
    .green_i  (s_axis_tdata[2*PIX_W-1:PIX_W]),
    .blue_i   (s_axis_tdata[3*PIX_W-1:2*PIX_W]),
    .column_i (s_axis_tdata[3*PIX_W+COLUMN_BITS-1:3*PIX_W]),
    .last_i   (s_axis_tlast),
    .push_o   (push),
    .item_o   (push_item),
    .full_i   (full)
  );

  brs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .avail_o (avail),
    .item_o  (pop_item)
  );

  // counting and drive decision
  brs_back #(
    .COUNT_BITS(COUNT_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .avail_i        (avail),
    .item_i         (pop_item),
    .pop_o          (pop),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .left_count_o   (left_count),
    .center_count_o (center_count),
    .right_count_o  (right_count),
    .linear_cmd_o   (linear_cmd),
    .turn_cmd_o     (turn_cmd)
  );

  // result beat packing
  assign m_axis_tdata = OutW'({turn_cmd, linear_cmd, right_count, center_count, left_count});

endmodule

>>> rtl/brs_checker.sv
module brs_checker #(
  parameter int COLUMN_BITS = brs_pkg::COLUMN_BITS_DEF,
  parameter int COUNT_BITS  = brs_pkg::COUNT_BITS_DEF
) (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                s_axis_tvalid,
  input logic                                s_axis_tready,
  input logic                                s_axis_tlast,
  // left_count, center_count, right_count, linear_cmd, turn_cmd
  input logic [((3*COUNT_BITS+2*brs_pkg::CMD_W+7)/8)*8-1:0] m_axis_tdata,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready
);
  import brs_pkg::*;

  localparam int PendW = 4;

  logic [COUNT_BITS-1:0] left_c, center_c, right_c;
  logic [CMD_W-1:0]      lin_c, turn_c;
  logic                  in_last_beat;
  logic                  out_beat;
  logic [PendW-1:0]      pend_q;

  assign left_c   = m_axis_tdata[COUNT_BITS-1:0];
  assign center_c = m_axis_tdata[2*COUNT_BITS-1:COUNT_BITS];
  assign right_c  = m_axis_tdata[3*COUNT_BITS-1:2*COUNT_BITS];
  assign lin_c    = m_axis_tdata[3*COUNT_BITS+CMD_W-1:3*COUNT_BITS];
  assign turn_c   = m_axis_tdata[3*COUNT_BITS+2*CMD_W-1:3*COUNT_BITS+CMD_W];

  assign in_last_beat = s_axis_tvalid && s_axis_tready && s_axis_tlast;
  assign out_beat     = m_axis_tvalid && m_axis_tready;

  // frames accepted but not yet answered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + PendW'(in_last_beat) - PendW'(out_beat);
    end
  end

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed under stall");

  // no result without a frame end
  a_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> pend_q != '0)
    else $error("result beat without an open frame");

  // only -1, 0, +1 appear on the command fields
  a_codes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (lin_c != 2'b10) && (turn_c != 2'b10))
    else $error("illegal drive command code");

  // left turn only when left band strictly leads
  a_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (turn_c == CMD_NEG) |-> (left_c > center_c) && (left_c > right_c))
    else $error("left turn without a left lead");

  // right turn only when right band strictly leads
  a_right: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (turn_c == CMD_POS) |-> (right_c > center_c) && (right_c > left_c))
    else $error("right turn without a right lead");

endmodule

bind bright_region_steering brs_checker #(
  .COLUMN_BITS(COLUMN_BITS),
  .COUNT_BITS (COUNT_BITS)
) u_brs_checker (.*);

>>> bench/bright_region_steering_tb.sv
`timescale 1ns / 100ps

module bright_region_steering_tb;
  import brs_pkg::*;

  localparam int COL_W  = COLUMN_BITS_DEF;
  localparam int CNT_W  = COUNT_BITS_DEF;
  localparam int IN_W   = ((3*PIX_W+COL_W+7)/8)*8;
  localparam int OUT_W  = ((3*CNT_W+2*CMD_W+7)/8)*8;
  localparam int COL_LO = 3*PIX_W;
  localparam int DRAIN_CYCLES   = 12;
  localparam int WATCHDOG_LIMIT = 2000;

  // result beat, left_count in the low bits
  typedef struct packed {
    logic [CMD_W-1:0] turn;
    logic [CMD_W-1:0] linear;
    logic [CNT_W-1:0] right_cnt;
    logic [CNT_W-1:0] center_cnt;
    logic [CNT_W-1:0] left_cnt;
  } steer_result_t;

  // band counting and steering decision, plus the queue of pending frame results
  class steering_scoreboard;
    cfg_t             regs;
    logic [CNT_W-1:0] left_tot, center_tot, right_tot;
    steer_result_t    expected_q[$];
    int unsigned      mismatches;
    int unsigned      results_seen;

    function new();
      regs.bright_level = RST_BRIGHT_LEVEL;
      regs.band_width   = RST_BAND_WIDTH;
      regs.right_start  = RST_RIGHT_START;
      regs.near_limit   = RST_NEAR_LIMIT;
      regs.far_limit    = RST_FAR_LIMIT;
      left_tot   = '0;
      center_tot = '0;
      right_tot  = '0;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_BRIGHT_LEVEL: regs.bright_level = val[LEVEL_W-1:0];
        CFG_BAND_WIDTH:   regs.band_width   = val[BAND_W-1:0];
        CFG_RIGHT_START:  regs.right_start  = val[BAND_W-1:0];
        CFG_NEAR_LIMIT:   regs.near_limit   = val[LIMIT_W-1:0];
        CFG_FAR_LIMIT:    regs.far_limit    = val[LIMIT_W-1:0];
        default: ;
      endcase
    endfunction

    // saturating increment
    function logic [CNT_W-1:0] bump(logic [CNT_W-1:0] cnt);
      return (cnt == '1) ? cnt : cnt + 1'b1;
    endfunction

    // one accepted pixel beat; a frame-end beat yields one expected result
    function void note_pixel(logic [7:0] red, logic [7:0] green, logic [7:0] blue,
                             logic [COL_W-1:0] col, logic last);
      logic [21:0]      luma_sum;
      logic [7:0]       gray;
      int unsigned      w, rs, c;
      logic [CNT_W-1:0] peak;
      steer_result_t    res;
      luma_sum = 22'(red * 4899 + green * 9617 + blue * 1868 + 8192);
      gray = luma_sum[21:14];
      w  = 32'(regs.band_width);
      rs = 32'(regs.right_start);
      c  = 32'(col);
      // bands are compared without wrap, overlaps count in each band
      if (gray > regs.bright_level) begin
        if (c < w) left_tot = bump(left_tot);
        if (c >= w && c < 2 * w) center_tot = bump(center_tot);
        if (c >= rs && c < rs + w) right_tot = bump(right_tot);
      end
      if (!last) return;

      peak = left_tot;
      if (center_tot > peak) peak = center_tot;
      if (right_tot > peak) peak = right_tot;
      // forward test first, so crossed limits drive forward
      if (peak < regs.near_limit) res.linear = CMD_POS;
      else if (peak > regs.far_limit) res.linear = CMD_NEG;
      else res.linear = CMD_ZERO;

      if (left_tot > center_tot && left_tot > right_tot) res.turn = CMD_NEG;
      else if (center_tot > left_tot && center_tot > right_tot) res.turn = CMD_ZERO;
      else if (right_tot > left_tot && right_tot > center_tot) res.turn = CMD_POS;
      else begin
        // tie for the largest count: stop
        res.linear = CMD_ZERO;
        res.turn   = CMD_ZERO;
      end
      res.left_cnt   = left_tot;
      res.center_cnt = center_tot;
      res.right_cnt  = right_tot;
      expected_q.push_back(res);
      left_tot   = '0;
      center_tot = '0;
      right_tot  = '0;
    endfunction

    task report_mismatch(string what, longint unsigned got, longint unsigned want);
      mismatches++;
      if (mismatches <= 100)
        $display("mismatch at result %0d: %s got %0d expected %0d",
                 results_seen, what, got, want);
    endtask

    task check_result(steer_result_t got);
      steer_result_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        report_mismatch("result beat with no frame end pending, left_count",
                        got.left_cnt, 0);
        return;
      end
      want = expected_q.pop_front();
      if (got.left_cnt !== want.left_cnt)
        report_mismatch("left_count", got.left_cnt, want.left_cnt);
      if (got.center_cnt !== want.center_cnt)
        report_mismatch("center_count", got.center_cnt, want.center_cnt);
      if (got.right_cnt !== want.right_cnt)
        report_mismatch("right_count", got.right_cnt, want.right_cnt);
      if (got.linear !== want.linear)
        report_mismatch("linear_cmd code", got.linear, want.linear);
      if (got.turn !== want.turn)
        report_mismatch("turn_cmd code", got.turn, want.turn);
    endtask
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic [IN_W-1:0]       s_axis_tdata;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic                  s_axis_tlast;
  logic [OUT_W-1:0]      m_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  steering_scoreboard sb = new();
  int unsigned gap_pct;
  int unsigned pixels_sent;
  int unsigned settings_used;
  int unsigned quiet_cycles = 0;

  bright_region_steering dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // beat monitors on both streams
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      sb.note_pixel(s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16],
                    s_axis_tdata[COL_LO+COL_W-1:COL_LO], s_axis_tlast);
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(steer_result_t'(m_axis_tdata));
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // result side back-pressure in random bursts
  initial begin
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk_i);
      end
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    sb.set_reg(idx, val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_setting(logic [CFG_DATA_W-1:0] level, logic [CFG_DATA_W-1:0] width,
                               logic [CFG_DATA_W-1:0] rstart, logic [CFG_DATA_W-1:0] near,
                               logic [CFG_DATA_W-1:0] far);
    write_reg(CFG_BRIGHT_LEVEL, level);
    write_reg(CFG_BAND_WIDTH, width);
    write_reg(CFG_RIGHT_START, rstart);
    write_reg(CFG_NEAR_LIMIT, near);
    write_reg(CFG_FAR_LIMIT, far);
    settings_used++;
  endtask

  // one pixel beat, with an optional gap before it
  task automatic send_pixel(logic [7:0] red, logic [7:0] green, logic [7:0] blue,
                            logic [COL_W-1:0] col, logic last);
    if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_W'({col, blue, green, red});
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    pixels_sent++;
  endtask

  // stop sending and let every pending frame result come out
  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    s_axis_tlast  <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // random frame: columns mostly near the bands, colors random, gray around the bright level, or bright gray
  task automatic run_frame(int unsigned len);
    int unsigned hi, w, rs, lvl, kind, v;
    logic [7:0]  red, green, blue;
    logic [COL_W-1:0] col;
    w   = 32'(sb.regs.band_width);
    rs  = 32'(sb.regs.right_start);
    lvl = 32'(sb.regs.bright_level);
    hi  = ((2 * w > rs + w) ? 2 * w : rs + w) + 2;
    if (hi > 4095) hi = 4095;
    for (int unsigned i = 0; i < len; i++) begin
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
        red   = 8'($urandom_range(0, 255));
        green = 8'($urandom_range(0, 255));
        blue  = 8'($urandom_range(0, 255));
      end else begin
        // equal components give a gray value equal to the component
        if (kind < 7) v = lvl + $urandom_range(0, 3);
        else v = $urandom_range(200, 256);
        v = (v == 0) ? 0 : v - 1;
        if (v > 255) v = 255;
        red   = 8'(v);
        green = 8'(v);
        blue  = 8'(v);
      end
      if ($urandom_range(0, 4) == 0) col = COL_W'($urandom_range(0, 4095));
      else col = COL_W'($urandom_range(0, hi));
      send_pixel(red, green, blue, col, i == len - 1);
    end
  endtask

  // random phase: frames, with occasional drains, until the beat budget is spent, then a drain
  task automatic run_phase(int budget);
    int unsigned len;
    while (budget > 0) begin
      len = $urandom_range(1, 20);
      run_frame(len);
      budget -= len;
      if ($urandom_range(0, 9) == 0) wait_drain();
    end
    wait_drain();
  endtask

  task automatic random_setting();
    apply_setting(20'($urandom_range(0, 255)), 20'($urandom_range(1, 24)),
                  20'($urandom_range(0, 60)), 20'($urandom_range(0, 20)),
                  20'($urandom_range(0, 20)));
  endtask

  task automatic run_directed();
    // default setting: band edges, threshold edge, columns past every band
    send_pixel(8'd255, 8'd255, 8'd255, 12'd0, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 12'd212, 1'b0);
    send_pixel(8'd241, 8'd241, 8'd241, 12'd213, 1'b0);
    send_pixel(8'd240, 8'd240, 8'd240, 12'd214, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 12'd425, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 12'd426, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 12'd638, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 12'd639, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 12'd4095, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd255, 12'd5, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 12'd1, 1'b1);
    // tie between left and center
    send_pixel(8'd255, 8'd255, 8'd255, 12'd0, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 12'd300, 1'b1);
    // empty frame, all counts zero
    send_pixel(8'd0, 8'd0, 8'd0, 12'd4095, 1'b1);
    // single bright pixel on the right
    send_pixel(8'd255, 8'd255, 8'd255, 12'd500, 1'b1);
    wait_drain();
    // zero band width counts nothing
    write_reg(CFG_BRIGHT_LEVEL, 20'd0);
    write_reg(CFG_BAND_WIDTH, 20'd0);
    send_pixel(8'd255, 8'd255, 8'd255, 12'd0, 1'b0);
    send_pixel(8'd1, 8'd1, 8'd1, 12'd0, 1'b1);
    wait_drain();
    // crossed limits, count between them still drives forward
    apply_setting(20'd0, 20'd4, 20'd8, 20'd10, 20'd5);
    for (int i = 0; i < 7; i++)
      send_pixel(8'd255, 8'd255, 8'd255, COL_W'(i % 4), i == 6);
    wait_drain();
  endtask

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    m_axis_tready <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CFG_BRIGHT_LEVEL;
    cfg_data_i    <= '0;
    gap_pct       = 20;
    pixels_sent   = 0;
    settings_used = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();

    // random phases, extremes first
    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: apply_setting(20'd0, 20'd1, 20'd0, 20'd0, 20'd0);
        1: apply_setting(20'd255, 20'd4095, 20'd4095, 20'hFFFFF, 20'hFFFFF);
        2: apply_setting(20'd0, 20'd4095, 20'd0, 20'd3, 20'd1);
        default: random_setting();
      endcase
      gap_pct = (ph % 3 == 2) ? 0 : $urandom_range(5, 35);
      run_phase(80);
    end

    // closing stretch at full rate on both sides
    gap_pct = 0;
    random_setting();
    run_phase(100);

    $display("covered %0d pixel beats over %0d register settings, stalls on both sides",
             pixels_sent, settings_used);
    $display("checked %0d frame results, %0d mismatches", sb.results_seen, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/brs_pkg.sv
rtl/brs_front.sv
rtl/brs_queue.sv
rtl/brs_back.sv
rtl/bright_region_steering.sv
rtl/brs_checker.sv
bench/bright_region_steering_tb.sv
